// ===== src/hnaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hnaf_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned LEAD_W   = 5;
    localparam int unsigned FLAG_W   = 4;
    localparam int unsigned TONE_W   = 10;
    localparam int unsigned BCNT_W   = 4;
    localparam int unsigned RUN_W    = 3;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h8408;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [DATA_W-1:0] HDLC_FLAG   = 8'h7E;
    localparam logic [DATA_W-1:0] LEAD_BYTE   = 8'h00;
    localparam logic [LEAD_W-1:0] LEAD_IN_MAX = 5'd30;
    localparam logic [LEAD_W-1:0] LEAD_RESET  = 5'd30;
    localparam logic [FLAG_W-1:0] FLAG_RESET  = 4'd4;
    localparam logic [RUN_W-1:0]  STUFF_LAST  = 3'd4;
    localparam logic [RUN_W-1:0]  RUN_SAT     = 3'd7;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_IN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS   = 1'b1;

    // Which byte of a frame the back end is producing.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_OPEN,
        PH_DATA,
        PH_FCS_LO,
        PH_FCS_HI,
        PH_CLOSE
    } t_phase;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              first;
        logic              last;
        t_phase            start_phase;
        logic [LEAD_W-1:0] start_cnt;
    } t_cmd;

    // Result of encoding one byte.
    typedef struct packed {
        logic [TONE_W-1:0] bits;
        logic [BCNT_W-1:0] cnt;
        logic              tone;
        logic [RUN_W-1:0]  run;
    } t_enc;

    // Reflected CRC-16 fold of one byte, least significant bit first.
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // NRZI coding with optional bit stuffing. A zero toggles the tone; with
    // stuffing on, a zero is inserted after the fifth one of a run.
    function automatic t_enc enc_byte(input logic [DATA_W-1:0] b,
                                      input logic              stuff,
                                      input logic              tone,
                                      input logic [RUN_W-1:0]  run);
        t_enc              r;
        logic [TONE_W-1:0] bits;
        logic [BCNT_W-1:0] cnt;
        logic              t;
        logic [RUN_W-1:0]  rn;
        bits = '0;
        cnt  = '0;
        t    = tone;
        rn   = run;
        for (int i = 0; i < 8; i++) begin
            if (!b[i]) begin
                t    = ~t;
                rn   = '0;
                bits = bits | (TONE_W'(t) << cnt);
                cnt  = cnt + 1'b1;
            end else begin
                bits = bits | (TONE_W'(t) << cnt);
                cnt  = cnt + 1'b1;
                if (stuff) begin
                    if (rn >= STUFF_LAST) begin
                        t    = ~t;
                        rn   = '0;
                        bits = bits | (TONE_W'(t) << cnt);
                        cnt  = cnt + 1'b1;
                    end else begin
                        rn = rn + 1'b1;
                    end
                end else if (rn != RUN_SAT) begin
                    rn = rn + 1'b1;
                end
            end
        end
        r.bits = bits;
        r.cnt  = cnt;
        r.tone = t;
        r.run  = rn;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/hnaf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnaf_front (
    input  wire logic [hnaf_pkg::DATA_W-1:0] i_data,
    input  wire logic                        i_first,
    input  wire logic                        i_last,
    input  wire logic [hnaf_pkg::LEAD_W-1:0] i_lead_in,
    input  wire logic [hnaf_pkg::FLAG_W-1:0] i_flag_cnt,
    output      hnaf_pkg::t_cmd              o_cmd
);
    import hnaf_pkg::*;

    logic [LEAD_W-1:0] lead_eff;

    // Lead-in settings above the maximum behave as the maximum.
    assign lead_eff = (i_lead_in > LEAD_IN_MAX) ? LEAD_IN_MAX : i_lead_in;

    always_comb begin
        o_cmd.data        = i_data;
        o_cmd.first       = i_first;
        o_cmd.last        = i_last;
        o_cmd.start_phase = PH_DATA;
        o_cmd.start_cnt   = '0;
        if (i_first) begin
            if (lead_eff != '0) begin
                o_cmd.start_phase = PH_LEAD;
                o_cmd.start_cnt   = lead_eff;
            end else if (i_flag_cnt != '0) begin
                o_cmd.start_phase = PH_OPEN;
                o_cmd.start_cnt   = LEAD_W'(i_flag_cnt);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/hnaf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnaf_queue #(
    parameter int unsigned DEPTH = hnaf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hnaf_pkg::t_cmd i_cmd,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      hnaf_pkg::t_cmd o_head,
    output      logic           o_head_valid
);
    import hnaf_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full       = (r_cnt == FULL_CNT);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/hnaf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnaf_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hnaf_pkg::t_cmd              i_head,
    input  wire logic                        i_head_valid,
    output      logic                        o_pop,
    input  wire logic [hnaf_pkg::FLAG_W-1:0] i_flag_cnt,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic [hnaf_pkg::TONE_W-1:0] o_tone_bits,
    output      logic [hnaf_pkg::BCNT_W-1:0] o_bit_count,
    output      logic                        o_group_last
);
    import hnaf_pkg::*;

    t_phase            r_phase, n_phase;
    logic [LEAD_W-1:0] r_cnt, n_cnt;
    logic              r_tone;
    logic [RUN_W-1:0]  r_run;
    logic [CRC_W-1:0]  r_crc;
    logic              r_ov;
    logic [TONE_W-1:0] r_bits;
    logic [BCNT_W-1:0] r_bcnt;
    logic              r_glast;

    logic              starting, fresh, slot, fire, done, stuff;
    t_phase            ph;
    logic [LEAD_W-1:0] cnt;
    logic              tone;
    logic [RUN_W-1:0]  run;
    logic [CRC_W-1:0]  crc, n_crc;
    logic [DATA_W-1:0] byte_val;
    t_enc              enc;

    assign starting = (r_phase == PH_IDLE);
    assign fresh    = starting && i_head.first;
    assign ph       = starting ? i_head.start_phase : r_phase;
    assign cnt      = starting ? i_head.start_cnt : r_cnt;
    assign tone     = fresh ? 1'b1 : r_tone;
    assign run      = fresh ? '0 : r_run;
    assign crc      = fresh ? CRC_INIT : r_crc;
    assign slot     = !r_ov || i_ready;
    assign fire     = i_head_valid && slot;
    assign o_pop    = fire && done;

    always_comb begin
        byte_val = i_head.data;
        stuff    = 1'b1;
        n_crc    = crc;
        n_phase  = r_phase;
        n_cnt    = cnt - 1'b1;
        done     = 1'b0;
        case (ph)
            PH_LEAD: begin
                byte_val = LEAD_BYTE;
                if (cnt == LEAD_W'(1)) begin
                    if (i_flag_cnt != '0) begin
                        n_phase = PH_OPEN;
                        n_cnt   = LEAD_W'(i_flag_cnt);
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_phase = PH_LEAD;
                end
            end
            PH_OPEN: begin
                byte_val = HDLC_FLAG;
                stuff    = 1'b0;
                n_phase  = (cnt == LEAD_W'(1)) ? PH_DATA : PH_OPEN;
            end
            PH_DATA: begin
                n_crc = crc_fold(crc, i_head.data);
                if (i_head.last) begin
                    n_phase = PH_FCS_LO;
                end else begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_FCS_LO: begin
                byte_val = ~crc[7:0];
                n_phase  = PH_FCS_HI;
            end
            PH_FCS_HI: begin
                byte_val = ~crc[15:8];
                if (i_flag_cnt != '0) begin
                    n_phase = PH_CLOSE;
                    n_cnt   = LEAD_W'(i_flag_cnt);
                end else begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_CLOSE: begin
                byte_val = HDLC_FLAG;
                stuff    = 1'b0;
                if (cnt == LEAD_W'(1)) begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_CLOSE;
                end
            end
            default: begin
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
        endcase
        enc = enc_byte(byte_val, stuff, tone, run);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_tone  <= 1'b1;
            r_run   <= '0;
            r_crc   <= CRC_INIT;
            r_ov    <= 1'b0;
        end else begin
            if (fire) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_tone  <= enc.tone;
                r_run   <= enc.run;
                r_crc   <= n_crc;
                r_ov    <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_bits  <= enc.bits;
            r_bcnt  <= enc.cnt;
            r_glast <= done;
        end
    end

    assign o_valid      = r_ov;
    assign o_tone_bits  = r_bits;
    assign o_bit_count  = r_bcnt;
    assign o_group_last = r_glast;

endmodule

`default_nettype wire

// ===== src/hdlc_nrzi_afsk_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Ports                      Contents
// s (bytes)  in         tvalid/tready/tdata/tuser/  tdata: data_byte; tuser: first_byte;
//                       tlast                      tlast: last_byte
// m (tones)  out        tvalid/tready/tdata/tlast  tdata: tone_bits, bit_count; tlast: group_last
// cfg        in         valid/ready/index/data     index 0 lead_in_bytes, 1 flag_count
//
// A plain data byte passes at one item per cycle while the output is not stalled.
// A first byte is preceded by lead_in zero bytes and opening flags, and a last byte is
// followed by the two FCS bytes and closing flags, all from the single byte encoder.
// The input side keeps filling a queue, two entries deep by default, while the back end works.
// Reset is synchronous and active low; it clears the queue, the output register,
// the tone (to mark), the ones run and the CRC. Either side may stall at any time.

module hdlc_nrzi_afsk_framer #(
    parameter int unsigned QUEUE_DEPTH = hnaf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Byte input.
    input  wire logic                           i_s_tvalid,
    output      logic                           o_s_tready,
    input  wire logic [7:0]                     i_s_tdata,  // [7:0] data_byte
    input  wire logic                           i_s_tuser,  // [0] first_byte
    input  wire logic                           i_s_tlast,
    // Tone group output.
    output      logic                           o_m_tvalid,
    input  wire logic                           i_m_tready,
    output      logic [15:0]                    o_m_tdata,  // [9:0] tone_bits, [13:10] bit_count
    output      logic                           o_m_tlast,
    // Configuration writes.
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic [hnaf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hnaf_pkg::LEAD_W-1:0]    i_cfg_data
);
    import hnaf_pkg::*;

    logic [LEAD_W-1:0] r_lead_in;
    logic [FLAG_W-1:0] r_flag_cnt;

    t_cmd              push_cmd, head_cmd;
    logic              q_full, head_valid, pop, push;
    logic [TONE_W-1:0] tone_bits;
    logic [BCNT_W-1:0] bit_count;

    // The register file always takes a write; the user must write only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_in  <= LEAD_RESET;
            r_flag_cnt <= FLAG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEAD_IN: r_lead_in  <= i_cfg_data;
                CFG_FLAGS:   r_flag_cnt <= i_cfg_data[FLAG_W-1:0];
                default:     r_lead_in  <= r_lead_in;
            endcase
        end
    end

    // An input item is taken whenever the queue has room.
    assign o_s_tready = !q_full;
    assign push       = i_s_tvalid && !q_full;

    hnaf_front u_front (
        .i_data     (i_s_tdata),
        .i_first    (i_s_tuser),
        .i_last     (i_s_tlast),
        .i_lead_in  (r_lead_in),
        .i_flag_cnt (r_flag_cnt),
        .o_cmd      (push_cmd)
    );

    hnaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head       (head_cmd),
        .o_head_valid (head_valid)
    );

    hnaf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_flag_cnt   (r_flag_cnt),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_tone_bits  (tone_bits),
        .o_bit_count  (bit_count),
        .o_group_last (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, bit_count, tone_bits};

endmodule

`default_nettype wire

// ===== src/hnaf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnaf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // A stalled group holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output group changed while stalled");

    // Stuffing adds at most two bits to a byte.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[13:10] == 4'd8 || o_m_tdata[13:10] == 4'd9 ||
                        o_m_tdata[13:10] == 4'd10))
        else $error("bit count out of range");

    // Tone bits past the count, and the padding, stay zero.
    a_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[13:10] != 4'd10 |->
            o_m_tdata[9] == 1'b0 && o_m_tdata[15:14] == 2'b00)
        else $error("tone bits beyond count not zero");

    a_eight_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[13:10] == 4'd8 |-> o_m_tdata[9:8] == 2'b00)
        else $error("tone bits beyond eight not zero");

endmodule

bind hdlc_nrzi_afsk_framer hnaf_checker u_hnaf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
